[src/dfcec_pkg.sv]
// Shared types and geometry constants of the face-circle event cut.
package dfcec_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_PASS       = 2'd0,
    ST_OUTSIDE    = 2'd1,
    ST_BAD_MODULE = 2'd2,
    ST_NO_VERTEX  = 2'd3
  } cut_status_t;

  // Module kind codes.
  typedef enum logic [1:0] {
    KIND_MAIN  = 2'd0,
    KIND_XWALL = 2'd1,
    KIND_GVETO = 2'd2,
    KIND_OTHER = 2'd3
  } module_kind_t;

  localparam int unsigned COORD_W = 17;  // signed width of centre and vertex math
  localparam int unsigned DIST_W  = 15;  // every |offset| stays below 2^15
  localparam int unsigned SQ_W    = 31;  // d1^2 + d2^2
  localparam int unsigned ROOT_W  = 16;
  localparam int unsigned CELLS   = 16;  // one root bit per cell

  // Main wall, plane YZ.
  localparam logic signed [COORD_W-1:0] MW_X       = 17'sd870;
  localparam logic signed [COORD_W-1:0] MW_Y_PITCH = 17'sd518;
  localparam logic signed [COORD_W-1:0] MW_Y_BASE  = -17'sd4921;
  localparam logic signed [COORD_W-1:0] MW_Z_PITCH = 17'sd518;
  localparam logic signed [COORD_W-1:0] MW_Z_BASE  = -17'sd3108;
  // X-wall, plane XZ.
  localparam logic signed [COORD_W-1:0] XW_X_OUTER = 17'sd666;
  localparam logic signed [COORD_W-1:0] XW_X_INNER = 17'sd260;
  localparam logic signed [COORD_W-1:0] XW_Y       = 17'sd5011;
  localparam logic signed [COORD_W-1:0] XW_Z_PITCH = 17'sd424;
  localparam logic signed [COORD_W-1:0] XW_Z_BASE  = -17'sd3180;
  // Gamma veto, plane XY.
  localparam logic signed [COORD_W-1:0] GV_X        = 17'sd427;
  localparam logic signed [COORD_W-1:0] GV_Y_PITCH  = 17'sd623;
  localparam logic signed [COORD_W-1:0] GV_Y_BASE_H = -17'sd4662;
  localparam logic signed [COORD_W-1:0] GV_Y_BASE_L = -17'sd4683;
  localparam logic signed [COORD_W-1:0] GV_Z        = 17'sd3100;

  // Offsets after the geometry stage.
  typedef struct packed {
    cut_status_t       status;
    logic [DIST_W-1:0] d1;
    logic [DIST_W-1:0] d2;
    logic [DIST_W-1:0] nd;
  } dist_t;

  // Squared offsets.
  typedef struct packed {
    cut_status_t         status;
    logic [2*DIST_W-1:0] p1;
    logic [2*DIST_W-1:0] p2;
    logic [DIST_W-1:0]   nd;
  } sqr_t;

  // Data handed from cell to cell along the root chain.
  typedef struct packed {
    cut_status_t       status;
    logic [DIST_W-1:0] nd;
    logic [SQ_W-1:0]   rem;
    logic [SQ_W-1:0]   root;
  } chain_t;

endpackage

[src/detector_face_circle_event_cut_unit.sv]
// Top level of the face-circle event cut: config register, front pipeline, root chain.
//
//  Channel  Handshake               Payload
//  -------  ----------------------  ------------------------------------------------
//  in_      in_valid / in_ready     hit, module kind and indices, vertex flag, x y z
//  out_     out_valid / out_ready   cut_status, face_radius, normal_distance
//  cfg_     cfg_valid / cfg_ready   cfg_max_radius (always ready)
//
// An item passes nineteen registers: three front stages (geometry, squaring, sum and
// compare) and one cell per root bit, sixteen in all. One item can be accepted in every
// cycle while the output is not stalled; the front stages and cells all hold one item.
// Reset is synchronous and active low; it empties the pipeline and sets the radius
// limit to 100. A stalled output holds its item, and each stage keeps taking items
// as long as some stage downstream of it is empty, so bubbles are squeezed out.
module detector_face_circle_event_cut_unit
  import dfcec_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_hit_present,
  input  logic [1:0]         in_module_kind,
  input  logic signed [1:0]  in_side_index,
  input  logic signed [5:0]  in_wall_index,
  input  logic signed [5:0]  in_column_index,
  input  logic signed [5:0]  in_row_index,
  input  logic               in_vertex_found,
  input  logic signed [14:0] in_vertex_x,
  input  logic signed [14:0] in_vertex_y,
  input  logic signed [14:0] in_vertex_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_cut_status,
  output logic [15:0]        out_face_radius,
  output logic [14:0]        out_normal_distance,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_max_radius
);

  logic [15:0] max_radius_r;
  logic [31:0] max_radius_sq_r;

  // The user must change the limit only while the block is idle; the block itself does
  // not enforce this. The squared copy is registered from the limit register, and is
  // then settled long before any item reaches the compare in the third front stage.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_radius_r    <= 16'd100;
      max_radius_sq_r <= 32'd10000;
    end else begin
      if (cfg_valid) max_radius_r <= cfg_max_radius;
      max_radius_sq_r <= 32'(max_radius_r) * 32'(max_radius_r);
    end
  end

  // Chain links: link 0 comes from the front pipeline, link CELLS is the output.
  logic   link_valid [0:CELLS];
  logic   link_ready [0:CELLS];
  chain_t link_data  [0:CELLS];

  dfcec_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (in_valid),
    .up_ready      (in_ready),
    .hit_present   (in_hit_present),
    .module_kind   (in_module_kind),
    .side_index    (in_side_index),
    .wall_index    (in_wall_index),
    .column_index  (in_column_index),
    .row_index     (in_row_index),
    .vertex_found  (in_vertex_found),
    .vertex_x      (in_vertex_x),
    .vertex_y      (in_vertex_y),
    .vertex_z      (in_vertex_z),
    .max_radius_sq (max_radius_sq_r),
    .dn_valid      (link_valid[0]),
    .dn_ready      (link_ready[0]),
    .dn_data       (link_data[0])
  );

  // The first cell tests the highest root bit; each later cell tests the next lower one.
  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    dfcec_root_cell #(
      .STEP (CELLS - 1 - g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (link_valid[g]),
      .up_ready (link_ready[g]),
      .up_data  (link_data[g]),
      .dn_valid (link_valid[g+1]),
      .dn_ready (link_ready[g+1]),
      .dn_data  (link_data[g+1])
    );
  end

  // The last cell's register is the output register. Rejected items enter the
  // chain with zero offsets, so their radius and normal distance come out zero.
  // The root of a 31-bit sum always fits in 16 bits, so no saturation is needed.
  assign link_ready[CELLS]   = out_ready;
  assign out_valid           = link_valid[CELLS];
  assign out_cut_status      = link_data[CELLS].status;
  assign out_face_radius     = link_data[CELLS].root[ROOT_W-1:0];
  assign out_normal_distance = link_data[CELLS].nd;

endmodule

[src/dfcec_front.sv]
// Front pipeline: module centre and offsets, squares, sum and radius compare.
module dfcec_front
  import dfcec_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  logic              hit_present,
  input  logic [1:0]        module_kind,
  input  logic signed [1:0] side_index,
  input  logic signed [5:0] wall_index,
  input  logic signed [5:0] column_index,
  input  logic signed [5:0] row_index,
  input  logic              vertex_found,
  input  logic signed [14:0] vertex_x,
  input  logic signed [14:0] vertex_y,
  input  logic signed [14:0] vertex_z,
  input  logic [31:0]       max_radius_sq,
  output logic              dn_valid,
  input  logic              dn_ready,
  output chain_t            dn_data
);

  logic   s0_valid_r, s1_valid_r, s2_valid_r;
  logic   s0_ready, s1_ready, s2_ready;
  dist_t  s0_r, s0_nxt;
  sqr_t   s1_r, s1_nxt;
  chain_t s2_r, s2_nxt;

  logic                      ok;
  logic                      pos_side, wall_one;
  module_kind_t              kind;
  logic signed [COORD_W-1:0] w_s, c_s, r_s;
  logic signed [COORD_W-1:0] cx, cy, cz;
  logic signed [COORD_W-1:0] vx, vy, vz;
  logic signed [COORD_W-1:0] dx, dy, dz;
  logic [DIST_W-1:0]         ax, ay, az;
  logic [SQ_W-1:0]           sq;

  assign s2_ready = !s2_valid_r || dn_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign s0_ready = !s0_valid_r || s1_ready;
  assign up_ready = s0_ready;

  // Stage 0: decode the module, place its window centre, take offsets.
  always_comb begin
    kind     = module_kind_t'(module_kind);
    pos_side = (side_index == 2'sd1);
    wall_one = (wall_index == 6'sd1);
    ok = hit_present && !side_index[1] && !wall_index[5] && !column_index[5]
         && !(kind == KIND_XWALL && row_index[5]) && (kind != KIND_OTHER);
    w_s = signed'({12'd0, wall_index[4:0]});
    c_s = signed'({12'd0, column_index[4:0]});
    r_s = signed'({12'd0, row_index[4:0]});
    vx  = COORD_W'(vertex_x);
    vy  = COORD_W'(vertex_y);
    vz  = COORD_W'(vertex_z);
    case (kind)
      KIND_MAIN: begin
        cx = pos_side ? MW_X : -MW_X;
        cy = w_s * MW_Y_PITCH + MW_Y_BASE;
        cz = c_s * MW_Z_PITCH + MW_Z_BASE;
      end
      KIND_XWALL: begin
        if (column_index == 6'sd1) begin
          cx = pos_side ? XW_X_OUTER : -XW_X_OUTER;
        end else begin
          cx = pos_side ? XW_X_INNER : -XW_X_INNER;
        end
        cy = wall_one ? XW_Y : -XW_Y;
        cz = r_s * XW_Z_PITCH + XW_Z_BASE;
      end
      KIND_GVETO: begin
        cx = pos_side ? GV_X : -GV_X;
        cy = c_s * GV_Y_PITCH + ((c_s > 17'sd7) ? GV_Y_BASE_H : GV_Y_BASE_L);
        cz = wall_one ? GV_Z : -GV_Z;
      end
      default: begin
        cx = '0;
        cy = '0;
        cz = '0;
      end
    endcase
    dx = vx - cx;
    dy = vy - cy;
    dz = vz - cz;
    ax = dx[COORD_W-1] ? DIST_W'(-dx) : DIST_W'(dx);
    ay = dy[COORD_W-1] ? DIST_W'(-dy) : DIST_W'(dy);
    az = dz[COORD_W-1] ? DIST_W'(-dz) : DIST_W'(dz);

    s0_nxt.status = ST_PASS;
    case (kind)
      KIND_MAIN: begin
        s0_nxt.d1 = ay;
        s0_nxt.d2 = az;
        s0_nxt.nd = ax;
      end
      KIND_XWALL: begin
        s0_nxt.d1 = ax;
        s0_nxt.d2 = az;
        s0_nxt.nd = ay;
      end
      default: begin
        s0_nxt.d1 = ax;
        s0_nxt.d2 = ay;
        s0_nxt.nd = az;
      end
    endcase
    // Rejected events carry zero offsets so the root chain yields zero.
    if (!ok || !vertex_found) begin
      s0_nxt.status = ok ? ST_NO_VERTEX : ST_BAD_MODULE;
      s0_nxt.d1     = '0;
      s0_nxt.d2     = '0;
      s0_nxt.nd     = '0;
    end
  end

  // Stage 1: square both in-plane offsets.
  always_comb begin
    s1_nxt.status = s0_r.status;
    s1_nxt.p1     = (2*DIST_W)'(s0_r.d1) * (2*DIST_W)'(s0_r.d1);
    s1_nxt.p2     = (2*DIST_W)'(s0_r.d2) * (2*DIST_W)'(s0_r.d2);
    s1_nxt.nd     = s0_r.nd;
  end

  // Stage 2: sum the squares and compare against the squared limit.
  always_comb begin
    sq             = SQ_W'(s1_r.p1) + SQ_W'(s1_r.p2);
    s2_nxt.status  = s1_r.status;
    if (s1_r.status == ST_PASS) begin
      s2_nxt.status = ({1'b0, sq} <= max_radius_sq) ? ST_PASS : ST_OUTSIDE;
    end
    s2_nxt.nd   = s1_r.nd;
    s2_nxt.rem  = sq;
    s2_nxt.root = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s0_ready) s0_valid_r <= up_valid;
      if (s1_ready) s1_valid_r <= s0_valid_r;
      if (s2_ready) s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready && up_valid) s0_r <= s0_nxt;
    if (s1_ready && s0_valid_r) s1_r <= s1_nxt;
    if (s2_ready && s1_valid_r) s2_r <= s2_nxt;
  end

  assign dn_valid = s2_valid_r;
  assign dn_data  = s2_r;

endmodule

[src/dfcec_root_cell.sv]
// One cell of the square-root chain: settles one result bit per item.
module dfcec_root_cell
  import dfcec_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   up_valid,
  output logic   up_ready,
  input  chain_t up_data,
  output logic   dn_valid,
  input  logic   dn_ready,
  output chain_t dn_data
);

  localparam logic [SQ_W-1:0] BIT_VAL = SQ_W'(1) << (2 * STEP);

  logic          valid_r;
  chain_t        data_r, data_nxt;
  logic [SQ_W:0] trial;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    trial    = {1'b0, up_data.root} + {1'b0, BIT_VAL};
    data_nxt = up_data;
    if ({1'b0, up_data.rem} >= trial) begin
      data_nxt.rem  = up_data.rem - trial[SQ_W-1:0];
      data_nxt.root = (up_data.root >> 1) + BIT_VAL;
    end else begin
      data_nxt.root = up_data.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) data_r <= data_nxt;
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule
